// ===== hdl/rfa_pkg.sv =====
// ============================================================================
// rfa_pkg: shared types and codes for the rational fraction ALU
// Holds the transaction structs, operation and status codes, sequencer states.
// ============================================================================
package rfa_pkg;

	localparam int WIDTH = 32;
	localparam int MW = 64;                 // magnitude width of intermediates

	typedef enum logic [2:0] {
		ACT_ADD    = 3'd0,
		ACT_SUB    = 3'd1,
		ACT_MUL    = 3'd2,
		ACT_DIV    = 3'd3,
		ACT_CMP    = 3'd4,
		ACT_REDUCE = 3'd5
	} act_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZDEN = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;
	localparam logic [1:0] ST_OVF  = 2'd3;

	localparam logic [1:0] ORD_LT = 2'd0;
	localparam logic [1:0] ORD_EQ = 2'd1;
	localparam logic [1:0] ORD_GT = 2'd2;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] num_a;
		logic signed [31:0] den_a;
		logic signed [31:0] num_b;
		logic signed [31:0] den_b;
	} rfa_in_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic [1:0]         order;
		logic [1:0]         status;
	} rfa_out_t;

	// shared divide/multiply unit operations
	typedef enum logic [1:0] {
		UOP_MOD = 2'd0,
		UOP_DIV = 2'd1,
		UOP_MUL = 2'd2
	} uop_t;

	typedef struct packed {
		logic       go;
		uop_t       op;
		logic [MW-1:0] x;
		logic [MW-1:0] y;
	} unit_req_t;

	typedef struct packed {
		logic          done;
		logic [MW-1:0] quo;
		logic [MW-1:0] rem;
	} unit_rsp_t;

	typedef enum logic [5:0] {
		S_IDLE,
		S_CHECK,
		// reduce a
		S_A_INIT, S_A_GCD, S_A_GCDW, S_A_DN, S_A_DNW, S_A_DD, S_A_DDW,
		// reduce b
		S_B_INIT, S_B_GCD, S_B_GCDW, S_B_DN, S_B_DNW, S_B_DD, S_B_DDW,
		// dispatch
		S_OPSEL,
		// add/sub
		S_L_GCD, S_L_GCDW, S_L_Q, S_L_QW, S_L_M, S_L_MW,
		S_L_FA, S_L_FAW, S_L_MA, S_L_MAW, S_L_FB, S_L_FBW, S_L_MB, S_L_MBW, S_L_SUM,
		// mul/div products
		S_P_N, S_P_NW, S_P_D, S_P_DW,
		// compare
		S_C_L, S_C_LW, S_C_R, S_C_RW, S_C_CMP,
		// final reduce
		S_F_INIT, S_F_GCD, S_F_GCDW, S_F_DN, S_F_DNW, S_F_DD, S_F_DDW, S_F_CHK,
		S_DONE
	} state_t;

endpackage

// ===== hdl/rational_fraction_alu_top.sv =====
// ============================================================================
// rational_fraction_alu_top: exact signed fraction arithmetic
// Add, subtract, multiply, divide, compare and reduce with gcd reduction,
// driven by a sequencer over one shared 64-bit divide/multiply unit.
// ============================================================================
//  channel   handshake          payload
//  ------    ---------          -------
//  request   start / busy       req  (rfa_pkg::rfa_in_t)
//  result    done strobe        rsp  (rfa_pkg::rfa_out_t)
//
//  Each unit operation is an issue state and a wait state, which holds through
//  the 64 bit steps in the shared unit and ends on its done pulse. Every gcd step,
//  division and multiplication is one such operation, so a transaction is
//  shortest on a zero denominator and longest on long Euclid chains on
//  64-bit values.
//  Reset clears the sequencer; busy is low after reset.
//  done is high for one cycle with the result; the receiver cannot stall.
module rational_fraction_alu_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rfa_pkg::rfa_in_t   req,
	output logic               done,
	output rfa_pkg::rfa_out_t  rsp
);

	localparam int MW = rfa_pkg::MW;
	localparam logic [MW-1:0] MAXPOS = MW'((64'd1 << (rfa_pkg::WIDTH - 1)) - 64'd1);

	rfa_pkg::state_t state_q, state_d;
	rfa_pkg::unit_req_t ureq;
	rfa_pkg::unit_rsp_t ursp;

	rfa_pkg::rfa_in_t in_q;
	logic [2:0]    act_q;
	logic          an_q, bn_q, fn_q;
	logic [MW-1:0] an_m_q, ad_m_q, bn_m_q, bd_m_q;
	logic [MW-1:0] g1_q, g2_q;           // Euclid pair
	logic [MW-1:0] l_q, ma_q, mb_q, t_q;
	logic [MW-1:0] fn_m_q, fd_m_q;
	logic signed [MW-1:0] lhs_q;
	rfa_pkg::rfa_out_t out_q;
	logic          done_q;

	rfa_unit u_unit (.clk(clk), .arst_n(arst_n), .req(ureq), .rsp(ursp));

	logic zden;
	logic [2:0] act_c;
	logic sb;
	logic signed [MW-1:0] rhs_s;

	// magnitude of a two's complement operand, widened to the unit width
	function automatic logic [MW-1:0] mag_of(logic signed [31:0] v);
		logic [32:0] e;
		e = {v[31], v};
		if (v[31])
			e = 33'd0 - e;
		return {{(MW-33){1'b0}}, e};
	endfunction

	// decode the request held in in_q
	always_comb begin
		act_c = (in_q.action > 3'd5) ? 3'(rfa_pkg::ACT_REDUCE) : in_q.action;
		zden  = (in_q.den_a == 32'sd0) ||
			(act_c != 3'(rfa_pkg::ACT_REDUCE) && in_q.den_b == 32'sd0);
		sb    = ((act_q == 3'(rfa_pkg::ACT_SUB)) ? !bn_q : bn_q) && (bn_m_q != '0);
		rhs_s = bn_q ? -$signed(ursp.rem) : $signed(ursp.rem);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rfa_pkg::S_IDLE:   if (start) state_d = rfa_pkg::S_CHECK;
			rfa_pkg::S_CHECK:  state_d = zden ? rfa_pkg::S_DONE : rfa_pkg::S_A_INIT;
			rfa_pkg::S_A_INIT: state_d = (an_m_q == '0) ? rfa_pkg::S_B_INIT : rfa_pkg::S_A_GCD;
			rfa_pkg::S_A_GCD:  state_d = (g2_q == '0) ? rfa_pkg::S_A_DN : rfa_pkg::S_A_GCDW;
			rfa_pkg::S_A_GCDW: if (ursp.done) state_d = rfa_pkg::S_A_GCD;
			rfa_pkg::S_A_DN:   state_d = rfa_pkg::S_A_DNW;
			rfa_pkg::S_A_DNW:  if (ursp.done) state_d = rfa_pkg::S_A_DD;
			rfa_pkg::S_A_DD:   state_d = rfa_pkg::S_A_DDW;
			rfa_pkg::S_A_DDW:  if (ursp.done) state_d = rfa_pkg::S_B_INIT;
			rfa_pkg::S_B_INIT: begin
				if (act_q == 3'(rfa_pkg::ACT_REDUCE)) state_d = rfa_pkg::S_F_INIT;
				else if (bn_m_q == '0) state_d = rfa_pkg::S_OPSEL;
				else state_d = rfa_pkg::S_B_GCD;
			end
			rfa_pkg::S_B_GCD:  state_d = (g2_q == '0) ? rfa_pkg::S_B_DN : rfa_pkg::S_B_GCDW;
			rfa_pkg::S_B_GCDW: if (ursp.done) state_d = rfa_pkg::S_B_GCD;
			rfa_pkg::S_B_DN:   state_d = rfa_pkg::S_B_DNW;
			rfa_pkg::S_B_DNW:  if (ursp.done) state_d = rfa_pkg::S_B_DD;
			rfa_pkg::S_B_DD:   state_d = rfa_pkg::S_B_DDW;
			rfa_pkg::S_B_DDW:  if (ursp.done) state_d = rfa_pkg::S_OPSEL;
			rfa_pkg::S_OPSEL: begin
				case (act_q)
					3'(rfa_pkg::ACT_ADD), 3'(rfa_pkg::ACT_SUB): state_d = rfa_pkg::S_L_GCD;
					3'(rfa_pkg::ACT_MUL): state_d = rfa_pkg::S_P_N;
					3'(rfa_pkg::ACT_DIV):
						state_d = (bn_m_q == '0) ? rfa_pkg::S_DONE : rfa_pkg::S_P_N;
					default: state_d = rfa_pkg::S_C_L;
				endcase
			end
			rfa_pkg::S_L_GCD:  state_d = (g2_q == '0) ? rfa_pkg::S_L_Q : rfa_pkg::S_L_GCDW;
			rfa_pkg::S_L_GCDW: if (ursp.done) state_d = rfa_pkg::S_L_GCD;
			rfa_pkg::S_L_Q:    state_d = rfa_pkg::S_L_QW;
			rfa_pkg::S_L_QW:   if (ursp.done) state_d = rfa_pkg::S_L_M;
			rfa_pkg::S_L_M:    state_d = rfa_pkg::S_L_MW;
			rfa_pkg::S_L_MW:   if (ursp.done) state_d = rfa_pkg::S_L_FA;
			rfa_pkg::S_L_FA:   state_d = rfa_pkg::S_L_FAW;
			rfa_pkg::S_L_FAW:  if (ursp.done) state_d = rfa_pkg::S_L_MA;
			rfa_pkg::S_L_MA:   state_d = rfa_pkg::S_L_MAW;
			rfa_pkg::S_L_MAW:  if (ursp.done) state_d = rfa_pkg::S_L_FB;
			rfa_pkg::S_L_FB:   state_d = rfa_pkg::S_L_FBW;
			rfa_pkg::S_L_FBW:  if (ursp.done) state_d = rfa_pkg::S_L_MB;
			rfa_pkg::S_L_MB:   state_d = rfa_pkg::S_L_MBW;
			rfa_pkg::S_L_MBW:  if (ursp.done) state_d = rfa_pkg::S_L_SUM;
			rfa_pkg::S_L_SUM:  state_d = rfa_pkg::S_F_INIT;
			rfa_pkg::S_P_N:    state_d = rfa_pkg::S_P_NW;
			rfa_pkg::S_P_NW:   if (ursp.done) state_d = rfa_pkg::S_P_D;
			rfa_pkg::S_P_D:    state_d = rfa_pkg::S_P_DW;
			rfa_pkg::S_P_DW:   if (ursp.done) state_d = rfa_pkg::S_F_INIT;
			rfa_pkg::S_C_L:    state_d = rfa_pkg::S_C_LW;
			rfa_pkg::S_C_LW:   if (ursp.done) state_d = rfa_pkg::S_C_R;
			rfa_pkg::S_C_R:    state_d = rfa_pkg::S_C_RW;
			rfa_pkg::S_C_RW:   if (ursp.done) state_d = rfa_pkg::S_C_CMP;
			rfa_pkg::S_C_CMP:  state_d = rfa_pkg::S_DONE;
			rfa_pkg::S_F_INIT: state_d = (fn_m_q == '0) ? rfa_pkg::S_DONE : rfa_pkg::S_F_GCD;
			rfa_pkg::S_F_GCD:  state_d = (g2_q == '0) ? rfa_pkg::S_F_DN : rfa_pkg::S_F_GCDW;
			rfa_pkg::S_F_GCDW: if (ursp.done) state_d = rfa_pkg::S_F_GCD;
			rfa_pkg::S_F_DN:   state_d = rfa_pkg::S_F_DNW;
			rfa_pkg::S_F_DNW:  if (ursp.done) state_d = rfa_pkg::S_F_DD;
			rfa_pkg::S_F_DD:   state_d = rfa_pkg::S_F_DDW;
			rfa_pkg::S_F_DDW:  if (ursp.done) state_d = rfa_pkg::S_F_CHK;
			rfa_pkg::S_F_CHK:  state_d = rfa_pkg::S_DONE;
			rfa_pkg::S_DONE:   state_d = rfa_pkg::S_IDLE;
			default:           state_d = rfa_pkg::S_IDLE;
		endcase
	end

	// unit requests
	always_comb begin
		ureq    = '0;
		ureq.op = rfa_pkg::UOP_MOD;
		case (state_q)
			rfa_pkg::S_A_GCD, rfa_pkg::S_B_GCD, rfa_pkg::S_L_GCD, rfa_pkg::S_F_GCD: begin
				ureq.go = (g2_q != '0);
				ureq.x  = g1_q;
				ureq.y  = g2_q;
			end
			rfa_pkg::S_A_DN: begin ureq.go = 1'b1; ureq.op = rfa_pkg::UOP_DIV; ureq.x = an_m_q; ureq.y = g1_q; end
			rfa_pkg::S_A_DD: begin ureq.go = 1'b1; ureq.op = rfa_pkg::UOP_DIV; ureq.x = ad_m_q; ureq.y = g1_q; end
			rfa_pkg::S_B_DN: begin ureq.go = 1'b1; ureq.op = rfa_pkg::UOP_DIV; ureq.x = bn_m_q; ureq.y = g1_q; end
			rfa_pkg::S_B_DD: begin ureq.go = 1'b1; ureq.op = rfa_pkg::UOP_DIV; ureq.x = bd_m_q; ureq.y = g1_q; end
			rfa_pkg::S_F_DN: begin ureq.go = 1'b1; ureq.op = rfa_pkg::UOP_DIV; ureq.x = fn_m_q; ureq.y = g1_q; end
			rfa_pkg::S_F_DD: begin ureq.go = 1'b1; ureq.op = rfa_pkg::UOP_DIV; ureq.x = fd_m_q; ureq.y = g1_q; end
			rfa_pkg::S_L_Q:  begin ureq.go = 1'b1; ureq.op = rfa_pkg::UOP_DIV; ureq.x = ad_m_q; ureq.y = g1_q; end
			rfa_pkg::S_L_M:  begin ureq.go = 1'b1; ureq.op = rfa_pkg::UOP_MUL; ureq.x = t_q; ureq.y = bd_m_q; end
			rfa_pkg::S_L_FA: begin ureq.go = 1'b1; ureq.op = rfa_pkg::UOP_DIV; ureq.x = l_q; ureq.y = ad_m_q; end
			rfa_pkg::S_L_MA: begin ureq.go = 1'b1; ureq.op = rfa_pkg::UOP_MUL; ureq.x = an_m_q; ureq.y = t_q; end
			rfa_pkg::S_L_FB: begin ureq.go = 1'b1; ureq.op = rfa_pkg::UOP_DIV; ureq.x = l_q; ureq.y = bd_m_q; end
			rfa_pkg::S_L_MB: begin ureq.go = 1'b1; ureq.op = rfa_pkg::UOP_MUL; ureq.x = bn_m_q; ureq.y = t_q; end
			rfa_pkg::S_P_N: begin
				ureq.go = 1'b1; ureq.op = rfa_pkg::UOP_MUL; ureq.x = an_m_q;
				ureq.y  = (act_q == 3'(rfa_pkg::ACT_DIV)) ? bd_m_q : bn_m_q;
			end
			rfa_pkg::S_P_D: begin
				ureq.go = 1'b1; ureq.op = rfa_pkg::UOP_MUL; ureq.x = ad_m_q;
				ureq.y  = (act_q == 3'(rfa_pkg::ACT_DIV)) ? bn_m_q : bd_m_q;
			end
			rfa_pkg::S_C_L:  begin ureq.go = 1'b1; ureq.op = rfa_pkg::UOP_MUL; ureq.x = an_m_q; ureq.y = bd_m_q; end
			rfa_pkg::S_C_R:  begin ureq.go = 1'b1; ureq.op = rfa_pkg::UOP_MUL; ureq.x = bn_m_q; ureq.y = ad_m_q; end
			default: ureq.go = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfa_pkg::S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == rfa_pkg::S_DONE);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			rfa_pkg::S_IDLE: if (start) in_q <= req;
			rfa_pkg::S_CHECK: begin
				act_q  <= act_c;
				out_q  <= '{res_num: '0, res_den: '0, order: rfa_pkg::ORD_LT,
					status: zden ? rfa_pkg::ST_ZDEN : rfa_pkg::ST_OK};
				an_q   <= in_q.num_a[31] ^ in_q.den_a[31];
				bn_q   <= in_q.num_b[31] ^ in_q.den_b[31];
				an_m_q <= mag_of(in_q.num_a);
				ad_m_q <= mag_of(in_q.den_a);
				bn_m_q <= mag_of(in_q.num_b);
				bd_m_q <= mag_of(in_q.den_b);
			end
			rfa_pkg::S_A_INIT: begin
				g1_q <= an_m_q; g2_q <= ad_m_q;
				if (an_m_q == '0) begin an_q <= 1'b0; ad_m_q <= MW'(1); end
			end
			rfa_pkg::S_B_INIT: begin
				g1_q <= bn_m_q; g2_q <= bd_m_q;
				fn_q <= an_q; fn_m_q <= an_m_q; fd_m_q <= ad_m_q;
				if (bn_m_q == '0) begin bn_q <= 1'b0; bd_m_q <= MW'(1); end
			end
			rfa_pkg::S_A_GCDW, rfa_pkg::S_B_GCDW, rfa_pkg::S_L_GCDW, rfa_pkg::S_F_GCDW:
				if (ursp.done) begin g1_q <= g2_q; g2_q <= ursp.rem; end
			rfa_pkg::S_A_DNW: if (ursp.done) an_m_q <= ursp.quo;
			rfa_pkg::S_A_DDW: if (ursp.done) ad_m_q <= ursp.quo;
			rfa_pkg::S_B_DNW: if (ursp.done) bn_m_q <= ursp.quo;
			rfa_pkg::S_B_DDW: if (ursp.done) bd_m_q <= ursp.quo;
			rfa_pkg::S_OPSEL: begin
				g1_q <= ad_m_q; g2_q <= bd_m_q;
				if (act_q == 3'(rfa_pkg::ACT_DIV) && bn_m_q == '0)
					out_q.status <= rfa_pkg::ST_DIV0;
			end
			rfa_pkg::S_L_QW:  if (ursp.done) t_q <= ursp.quo;
			rfa_pkg::S_L_MW:  if (ursp.done) l_q <= ursp.rem;
			rfa_pkg::S_L_FAW: if (ursp.done) t_q <= ursp.quo;
			rfa_pkg::S_L_MAW: if (ursp.done) ma_q <= ursp.rem;
			rfa_pkg::S_L_FBW: if (ursp.done) t_q <= ursp.quo;
			rfa_pkg::S_L_MBW: if (ursp.done) mb_q <= ursp.rem;
			rfa_pkg::S_L_SUM: begin
				fd_m_q <= l_q;
				if (an_q == sb) begin
					fn_q <= an_q; fn_m_q <= ma_q + mb_q;
				end else if (ma_q >= mb_q) begin
					fn_q <= an_q; fn_m_q <= ma_q - mb_q;
				end else begin
					fn_q <= sb; fn_m_q <= mb_q - ma_q;
				end
			end
			rfa_pkg::S_P_NW: if (ursp.done) begin fn_m_q <= ursp.rem; fn_q <= an_q ^ bn_q; end
			rfa_pkg::S_P_DW: if (ursp.done) fd_m_q <= ursp.rem;
			rfa_pkg::S_C_LW: if (ursp.done) lhs_q <= an_q ? -$signed(ursp.rem) : $signed(ursp.rem);
			rfa_pkg::S_C_RW: if (ursp.done) t_q <= MW'(rhs_s);
			rfa_pkg::S_C_CMP:
				out_q.order <= (lhs_q < $signed(t_q)) ? rfa_pkg::ORD_LT :
					((lhs_q == $signed(t_q)) ? rfa_pkg::ORD_EQ : rfa_pkg::ORD_GT);
			rfa_pkg::S_F_INIT: begin
				g1_q <= fn_m_q; g2_q <= fd_m_q;
				if (fn_m_q == '0) begin out_q.res_num <= '0; out_q.res_den <= 31'd1; end
			end
			rfa_pkg::S_F_DNW: if (ursp.done) fn_m_q <= ursp.quo;
			rfa_pkg::S_F_DDW: if (ursp.done) fd_m_q <= ursp.quo;
			rfa_pkg::S_F_CHK: begin
				if (fd_m_q > MAXPOS || (fn_q ? fn_m_q > MAXPOS + MW'(1) : fn_m_q > MAXPOS))
					out_q.status <= rfa_pkg::ST_OVF;
				else begin
					out_q.res_num <= fn_q ? -fn_m_q[31:0] : fn_m_q[31:0];
					out_q.res_den <= fd_m_q[30:0];
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != rfa_pkg::S_IDLE);
	assign done = done_q;
	assign rsp  = out_q;

	property p_done_idle;
		@(posedge clk) disable iff (!arst_n) done_q |-> state_q == rfa_pkg::S_IDLE;
	endproperty
	a_done_idle: assert property (p_done_idle) else $error("done while busy");

	property p_start_busy;
		@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy;
	endproperty
	a_start_busy: assert property (p_start_busy) else $error("start not taken");

	property p_err_zero;
		@(posedge clk) disable iff (!arst_n)
			(done_q && out_q.status != rfa_pkg::ST_OK) |-> (out_q.res_den == 31'd0);
	endproperty
	a_err_zero: assert property (p_err_zero) else $error("error result not cleared");

endmodule

// ===== hdl/rfa_unit.sv =====
// ============================================================================
// rfa_unit: shared multi-cycle arithmetic unit
// Radix-2 restoring divide (quotient and remainder) and shift-add multiply
// on 64-bit magnitudes, one bit per cycle.
// ============================================================================
module rfa_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  rfa_pkg::unit_req_t  req,
	output rfa_pkg::unit_rsp_t  rsp
);

	localparam int MW = rfa_pkg::MW;

	logic          busy_q;
	logic          mul_q;
	logic [6:0]    cnt_q;
	logic [MW-1:0] a_q;     // dividend shifting out / multiplier
	logic [MW-1:0] b_q;     // divisor / multiplicand
	logic [MW-1:0] r_q;     // remainder / product
	logic          done_q;

	logic [MW:0]   trial;
	logic [MW-1:0] rsh;

	// one step of the restoring divide
	always_comb begin
		rsh   = {r_q[MW-2:0], a_q[MW-1]};
		trial = {1'b0, rsh} - {1'b0, b_q};
	end

	// iterate one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(MW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go && !busy_q) begin
			mul_q <= (req.op == rfa_pkg::UOP_MUL);
			a_q   <= req.x;
			b_q   <= req.y;
			r_q   <= '0;
		end else if (busy_q) begin
			if (mul_q) begin
				// shift-add from the top bit
				r_q <= {r_q[MW-2:0], 1'b0} + (a_q[MW-1] ? b_q : '0);
				a_q <= {a_q[MW-2:0], 1'b0};
			end else if (!trial[MW]) begin
				r_q <= trial[MW-1:0];
				a_q <= {a_q[MW-2:0], 1'b1};
			end else begin
				r_q <= rsh;
				a_q <= {a_q[MW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.quo  = a_q;
		rsp.rem  = r_q;
	end

	property p_done_single;
		@(posedge clk) disable iff (!arst_n) done_q |=> !done_q;
	endproperty
	a_done_single: assert property (p_done_single) else $error("unit done held");

	property p_busy_ends;
		@(posedge clk) disable iff (!arst_n) (busy_q && cnt_q == 7'd1) |=> (done_q && !busy_q);
	endproperty
	a_busy_ends: assert property (p_busy_ends) else $error("unit done missing");

	property p_cnt_range;
		@(posedge clk) disable iff (!arst_n) busy_q |-> (cnt_q != 7'd0);
	endproperty
	a_cnt_range: assert property (p_cnt_range) else $error("unit count underflow");

endmodule
